// ===== rtl/rtpaac_pkg.sv =====
// ----------------------------------------------------------------------------
// rtpaac_pkg
// Shared types and constants of the RTP/AAC packetizer: packet command word
// passed from the frame parser to the packet emitter, header constants and
// configuration register indexes.
// ----------------------------------------------------------------------------
package rtpaac_pkg;

  // default largest payload chunk per packet
  localparam int MAX_BODY_DEF = 1400;

  // depth of the command queue between parser and emitter
  localparam int FIFO_DEPTH = 4;

  // ADTS header length in bytes
  localparam logic [12:0] ADTS_HDR_LEN = 13'd7;

  // fixed RTP / AU header content
  localparam logic [7:0]  RTP_BYTE0  = 8'h80;
  localparam logic [15:0] AU_HDR_LEN = 16'h0010;

  // byte positions inside one emitted packet
  localparam logic [4:0] HDR_LAST_IDX = 5'd15;
  localparam logic [4:0] DATA_IDX     = 5'd16;

  // configuration register reset values
  localparam logic [31:0] SSRC_RST    = 32'd0;
  localparam logic [31:0] TS_STEP_RST = 32'(90000 / 25);
  localparam logic [6:0]  PT_RST      = 7'd97;

  // configuration register indexes (byte address / 4)
  localparam logic [1:0] REG_SSRC    = 2'd0;
  localparam logic [1:0] REG_TS_STEP = 2'd1;
  localparam logic [1:0] REG_PTYPE   = 2'd2;

  // what the emitter does for one command
  typedef enum logic [1:0] {
    CMD_HDR_ONLY,
    CMD_HDR_DATA,
    CMD_DATA
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic        data_end;
    logic        marker;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [15:0] au_size;
  } pkt_cmd_t;

  // push side of the command queue
  typedef struct packed {
    logic     push;
    pkt_cmd_t cmd;
  } cmd_push_t;

endpackage

// ===== rtl/rtp_aac_packetizer.sv =====
// ----------------------------------------------------------------------------
// rtp_aac_packetizer
// RTP packetizer for ADTS-framed AAC: strips ADTS headers, chunks payload
// and emits RTP packets with an AU header section as a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one ADTS byte per word;
//   in_first_byte marks a frame start, and in_frame_length is read then.
//   Output channel (out_valid/out_ready) gives one packet byte per word with
//   start, end and last-of-command flags. Config is an APB-style port:
//   0x0 SSRC, 0x4 timestamp step, 0x8 payload type; write only while idle.
// Timing:
//   a payload byte passes through the command queue, the emitter's command
//   register and the output register; a packet header puts 16 header bytes
//   ahead of it. The output runs at one byte per cycle while out_ready is
//   high and commands are queued, set by the single-byte emitter. Input is
//   taken one word per cycle while the 4-entry command queue has room, so
//   sustained input is one word per cycle less each header's output time.
// Reset: sequence number, timestamp and frame state clear; registers take
//   SSRC 0, step 3600, payload type 97. When the receiver stalls, the output
//   word holds and the queue fills, then in_ready drops.
// ----------------------------------------------------------------------------
module rtp_aac_packetizer #(
  parameter int MAX_BODY = rtpaac_pkg::MAX_BODY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input byte channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_in,
  input  logic        in_first_byte,
  input  logic [12:0] in_frame_length,
  // packet byte channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_packet_start,
  output logic        out_packet_end,
  output logic        out_last_of_run,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rtpaac_pkg::*;

  logic [31:0] ssrc_r;
  logic [31:0] ts_step_r;
  logic [6:0]  ptype_r;
  logic        cfg_wr;
  logic [1:0]  reg_idx;

  cmd_push_t   q_wr;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  pkt_cmd_t    q_head;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ssrc_r    <= SSRC_RST;
      ts_step_r <= TS_STEP_RST;
      ptype_r   <= PT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SSRC:    ssrc_r    <= pwdata;
        REG_TS_STEP: ts_step_r <= pwdata;
        REG_PTYPE:   ptype_r   <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (reg_idx)
      REG_SSRC:    prdata = ssrc_r;
      REG_TS_STEP: prdata = ts_step_r;
      REG_PTYPE:   prdata = {25'd0, ptype_r};
      default:     prdata = '0;
    endcase
  end

  rtpaac_front #(
    .MAX_BODY (MAX_BODY)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_in      (in_data_in),
    .in_first_byte   (in_first_byte),
    .in_frame_length (in_frame_length),
    .ts_step         (ts_step_r),
    .q_full          (q_full),
    .q_wr            (q_wr)
  );

  rtpaac_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .head  (q_head)
  );

  rtpaac_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .ssrc             (ssrc_r),
    .ptype            (ptype_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_packet_start (out_packet_start),
    .out_packet_end   (out_packet_end),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

// ===== rtl/rtpaac_front.sv =====
// ----------------------------------------------------------------------------
// rtpaac_front
// Frame parser: accepts ADTS bytes, tracks the frame position, drops the
// ADTS header, splits payload into chunks and queues one command per
// byte that produces output.
// ----------------------------------------------------------------------------
module rtpaac_front #(
  parameter int MAX_BODY = rtpaac_pkg::MAX_BODY_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_in,
  input  logic                  in_first_byte,
  input  logic [12:0]           in_frame_length,
  input  logic [31:0]           ts_step,
  input  logic                  q_full,
  output rtpaac_pkg::cmd_push_t q_wr
);
  import rtpaac_pkg::*;

  localparam int PosW = $clog2(MAX_BODY + 1);
  localparam logic [PosW-1:0] MaxBodyPos = PosW'(MAX_BODY);
  localparam logic [12:0]     MaxBodyLen = 13'(MAX_BODY);
  localparam logic [2:0]      FposIdle    = 3'd0;
  localparam logic [2:0]      FposPayload = 3'd7;

  logic [15:0]     seq_r, seq_nxt;
  logic [31:0]     ts_cnt_r, ts_cnt_nxt;
  logic [2:0]      fpos_r, fpos_nxt;
  logic [12:0]     left_r, left_nxt;
  logic [PosW-1:0] ppos_r, ppos_nxt;
  logic [31:0]     fts_r, fts_nxt;

  logic            accept;
  logic [12:0]     flen_clamp;
  logic [12:0]     chunk_len;
  logic [12:0]     left_dec;
  logic [PosW-1:0] pos_inc;
  logic            chunk_end;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // per-byte frame tracking and command build
  always_comb begin
    seq_nxt    = seq_r;
    ts_cnt_nxt = ts_cnt_r;
    fpos_nxt   = fpos_r;
    left_nxt   = left_r;
    ppos_nxt   = ppos_r;
    fts_nxt    = fts_r;

    flen_clamp = (in_frame_length < ADTS_HDR_LEN) ? ADTS_HDR_LEN : in_frame_length;
    chunk_len  = (left_r <= MaxBodyLen) ? left_r : MaxBodyLen;
    left_dec   = left_r - 13'd1;
    pos_inc    = ppos_r + PosW'(1);
    chunk_end  = (pos_inc >= MaxBodyPos) || (left_dec == 13'd0);

    q_wr              = '0;
    q_wr.cmd.kind     = CMD_DATA;
    q_wr.cmd.data     = in_data_in;
    q_wr.cmd.seq      = seq_r;
    q_wr.cmd.ts       = fts_r;
    q_wr.cmd.marker   = (left_r <= MaxBodyLen);
    q_wr.cmd.au_size  = 16'({chunk_len, 3'b000});
    q_wr.cmd.data_end = chunk_end;

    if (accept) begin
      if (in_first_byte) begin
        // new frame: latch timestamp, restart counters
        left_nxt   = flen_clamp - ADTS_HDR_LEN;
        ppos_nxt   = '0;
        fts_nxt    = ts_cnt_r;
        ts_cnt_nxt = ts_cnt_r + ts_step;
        fpos_nxt   = 3'd1;
      end else if (fpos_r == FposIdle) begin
        // stray byte, dropped
      end else if (fpos_r != FposPayload) begin
        // ADTS header byte
        fpos_nxt = fpos_r + 3'd1;
        if ((fpos_r == FposPayload - 3'd1) && (left_r == 13'd0)) begin
          q_wr.push         = 1'b1;
          q_wr.cmd.kind     = CMD_HDR_ONLY;
          q_wr.cmd.marker   = 1'b1;
          q_wr.cmd.au_size  = 16'd0;
          q_wr.cmd.data_end = 1'b1;
          seq_nxt           = seq_r + 16'd1;
          fpos_nxt          = FposIdle;
        end
      end else if (left_r == 13'd0) begin
        fpos_nxt = FposIdle;
      end else begin
        // payload byte, with a packet header at chunk start
        q_wr.push = 1'b1;
        if (ppos_r == '0) begin
          q_wr.cmd.kind = CMD_HDR_DATA;
          seq_nxt       = seq_r + 16'd1;
        end
        left_nxt = left_dec;
        ppos_nxt = chunk_end ? '0 : pos_inc;
        if (left_dec == 13'd0) begin
          fpos_nxt = FposIdle;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r    <= '0;
      ts_cnt_r <= '0;
      fpos_r   <= FposIdle;
      left_r   <= '0;
      ppos_r   <= '0;
      fts_r    <= '0;
    end else begin
      seq_r    <= seq_nxt;
      ts_cnt_r <= ts_cnt_nxt;
      fpos_r   <= fpos_nxt;
      left_r   <= left_nxt;
      ppos_r   <= ppos_nxt;
      fts_r    <= fts_nxt;
    end
  end

endmodule

// ===== rtl/rtpaac_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// rtpaac_cmd_fifo
// Short command queue between the frame parser and the packet emitter.
// ----------------------------------------------------------------------------
module rtpaac_cmd_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rtpaac_pkg::cmd_push_t wr,
  output logic                  full,
  input  logic                  pop,
  output logic                  empty,
  output rtpaac_pkg::pkt_cmd_t  head
);
  import rtpaac_pkg::*;

  localparam int PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CntW = $clog2(FIFO_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(FIFO_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(FIFO_DEPTH);

  pkt_cmd_t        mem_r [FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign full    = (cnt_r == CntFull);
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = wr.push && !full;
  assign do_pop  = pop && !empty;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr.cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr.push |-> !full)
    else $error("command pushed into a full queue");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntFull)
    else $error("queue fill count out of range");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + CntW'(1)))
    else $error("queue fill count missed a push");

endmodule

// ===== rtl/rtpaac_back.sv =====
// ----------------------------------------------------------------------------
// rtpaac_back
// Packet emitter: expands each queued command into RTP header bytes and/or
// one payload byte, one byte per cycle while out_ready allows, through an output register.
// ----------------------------------------------------------------------------
module rtpaac_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  rtpaac_pkg::pkt_cmd_t q_head,
  output logic                 q_pop,
  input  logic [31:0]          ssrc,
  input  logic [6:0]           ptype,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_packet_start,
  output logic                 out_packet_end,
  output logic                 out_last_of_run
);
  import rtpaac_pkg::*;

  pkt_cmd_t   cmd_r;
  logic       active_r;
  logic [4:0] idx_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_start_r;
  logic       out_end_r;
  logic       out_last_r;

  logic       adv;
  logic       emit;
  logic [4:0] last_idx;
  logic       at_last;
  logic [7:0] sel_byte;
  logic       sel_end;

  assign adv      = !out_valid_r || out_ready;
  assign emit     = active_r && adv;
  assign last_idx = (cmd_r.kind == CMD_HDR_ONLY) ? HDR_LAST_IDX : DATA_IDX;
  assign at_last  = (idx_r == last_idx);
  assign q_pop    = (!active_r || (emit && at_last)) && !q_empty;

  // byte select for the current position
  always_comb begin
    case (idx_r)
      5'd0:    sel_byte = RTP_BYTE0;
      5'd1:    sel_byte = {cmd_r.marker, ptype};
      5'd2:    sel_byte = cmd_r.seq[15:8];
      5'd3:    sel_byte = cmd_r.seq[7:0];
      5'd4:    sel_byte = cmd_r.ts[31:24];
      5'd5:    sel_byte = cmd_r.ts[23:16];
      5'd6:    sel_byte = cmd_r.ts[15:8];
      5'd7:    sel_byte = cmd_r.ts[7:0];
      5'd8:    sel_byte = ssrc[31:24];
      5'd9:    sel_byte = ssrc[23:16];
      5'd10:   sel_byte = ssrc[15:8];
      5'd11:   sel_byte = ssrc[7:0];
      5'd12:   sel_byte = AU_HDR_LEN[15:8];
      5'd13:   sel_byte = AU_HDR_LEN[7:0];
      5'd14:   sel_byte = cmd_r.au_size[15:8];
      5'd15:   sel_byte = cmd_r.au_size[7:0];
      default: sel_byte = cmd_r.data;
    endcase
    sel_end = at_last && cmd_r.data_end;
  end

  // command register and position counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
    end else if (q_pop) begin
      active_r <= 1'b1;
      idx_r    <= (q_head.kind == CMD_DATA) ? DATA_IDX : '0;
    end else if (emit) begin
      if (at_last) begin
        active_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_head;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (adv) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r  <= sel_byte;
      out_start_r <= (idx_r == '0);
      out_end_r   <= sel_end;
      out_last_r  <= at_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_packet_start = out_start_r;
  assign out_packet_end   = out_end_r;
  assign out_last_of_run  = out_last_r;

  a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command taken from an empty queue");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (idx_r <= DATA_IDX))
    else $error("byte position past end of command");

  a_start_out: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && (idx_r == '0)) |=> (out_valid && out_packet_start && (out_byte == RTP_BYTE0)))
    else $error("packet start byte not presented");

  a_continue: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !at_last && !q_pop) |=> active_r)
    else $error("command dropped before its last byte");

endmodule
